// ----- src/npcs_pkg.sv -----
// Package for the nearest palette color search block.
// Holds the palette geometry, field widths and command codes.
// No dependencies; used by the top level, the checker and the testbench.
package npcs_pkg;

  localparam int PALETTE_DEPTH = 64;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);

  localparam int CHAN_W  = 8;
  localparam int ENTRY_W = 3 * CHAN_W;
  localparam int INDEX_W = 6;
  localparam int DIST_W  = 10;
  localparam int SIZE_W  = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
  localparam logic [DIST_W-1:0] DIST_MAX   = DIST_W'(765);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

endpackage

// ----- src/npcs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the palette store is one instance of it.
module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/nearest_palette_color_search.sv -----
// Top level of the nearest palette color search: palette RAM, scan control and result register.
// Depends on npcs_pkg and npcs_ram.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------------------------
//   in       | input     | in_valid_i / in_stall_o | command, entry_index, red, green, blue
//   out      | output    | out_valid_o/out_stall_i | nearest_index, nearest_distance
//   cfg      | input     | cfg_we_i               | cfg_wdata_i (palette_size)
//
// A write beat does not hold off the input; the block can accept the next beat right after it.
// A query beat holds off the input while it scans the entries up to the clamped palette size:
// the scan reads one palette entry per cycle through the single RAM read port.
// The result lands in an output register, so the input is freed when the scan ends if the
// output is free; a stalled output holds the finished scan until the register drains.
// Reset clears control state and sets palette_size to 64; the palette is undefined until written.
module nearest_palette_color_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [npcs_pkg::INDEX_W-1:0]  entry_index_i,
  input  logic [npcs_pkg::CHAN_W-1:0]   red_i,
  input  logic [npcs_pkg::CHAN_W-1:0]   green_i,
  input  logic [npcs_pkg::CHAN_W-1:0]   blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [npcs_pkg::INDEX_W-1:0]  nearest_index_o,
  output logic [npcs_pkg::DIST_W-1:0]   nearest_distance_o,
  input  logic                          cfg_we_i,
  input  logic [npcs_pkg::SIZE_W-1:0]   cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  localparam int AW = npcs_pkg::ADDR_W;
  localparam int CW = npcs_pkg::CHAN_W;
  localparam int DW = npcs_pkg::DIST_W;

  state_e                          state_q, state_d;
  logic [npcs_pkg::SIZE_W-1:0]     size_q;
  logic [AW-1:0]                   cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]                   last_q, last_d;
  logic [CW-1:0]                   pix_r_q, pix_g_q, pix_b_q;
  logic [AW-1:0]                   best_idx_q, best_idx_d;
  logic [DW-1:0]                   best_dist_q, best_dist_d;
  logic                            out_valid_q, out_valid_d;
  logic [npcs_pkg::INDEX_W-1:0]    out_idx_q, out_idx_d;
  logic [DW-1:0]                   out_dist_q, out_dist_d;

  logic                            in_accept;
  logic                            out_free;
  logic                            ram_we;
  logic [AW-1:0]                   ram_raddr;
  logic [npcs_pkg::ENTRY_W-1:0]    ram_rdata;
  logic [CW-1:0]                   ent_r, ent_g, ent_b;
  logic [CW-1:0]                   diff_r, diff_g, diff_b;
  logic [DW-1:0]                   cur_dist;
  logic                            take;
  logic [AW-1:0]                   new_idx;
  logic [DW-1:0]                   new_dist;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign ram_we = in_accept && (command_i == npcs_pkg::CMD_WRITE)
                  && (int'(entry_index_i) < npcs_pkg::PALETTE_DEPTH);

  // While idle the read port already fetches entry 0 so a query starts comparing next cycle.
  assign ram_raddr = (state_q == ST_SCAN) ? cmp_idx_q + 1'b1 : '0;

  npcs_ram #(
    .WIDTH (npcs_pkg::ENTRY_W),
    .DEPTH (npcs_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({red_i, green_i, blue_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Manhattan distance of the entry read this cycle against the held pixel.
  always_comb begin
    ent_r  = ram_rdata[3*CW-1:2*CW];
    ent_g  = ram_rdata[2*CW-1:CW];
    ent_b  = ram_rdata[CW-1:0];
    diff_r = (pix_r_q > ent_r) ? pix_r_q - ent_r : ent_r - pix_r_q;
    diff_g = (pix_g_q > ent_g) ? pix_g_q - ent_g : ent_g - pix_g_q;
    diff_b = (pix_b_q > ent_b) ? pix_b_q - ent_b : ent_b - pix_b_q;
    cur_dist = DW'(diff_r) + DW'(diff_g) + DW'(diff_b);
    // Only a strictly smaller distance replaces the best, so ties keep the lower index.
    take     = (cmp_idx_q == '0) || (cur_dist < best_dist_q);
    new_idx  = take ? cmp_idx_q : best_idx_q;
    new_dist = take ? cur_dist : best_dist_q;
  end

  // Last index to scan, with the palette size clamped to 1..PALETTE_DEPTH.
  always_comb begin
    if (size_q == '0) begin
      last_d = '0;
    end else if (int'(size_q) > npcs_pkg::PALETTE_DEPTH) begin
      last_d = AW'(npcs_pkg::PALETTE_DEPTH - 1);
    end else begin
      last_d = AW'(size_q - 1'b1);
    end
  end

  always_comb begin
    state_d     = state_q;
    cmp_idx_d   = cmp_idx_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_dist_d  = out_dist_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (command_i == npcs_pkg::CMD_QUERY)) begin
          cmp_idx_d = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        best_idx_d  = new_idx;
        best_dist_d = new_dist;
        if (cmp_idx_q == last_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_idx_d   = npcs_pkg::INDEX_W'(new_idx);
            out_dist_d  = new_dist;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          cmp_idx_d = cmp_idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = npcs_pkg::INDEX_W'(best_idx_q);
          out_dist_d  = best_dist_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      size_q      <= npcs_pkg::SIZE_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    out_idx_q   <= out_idx_d;
    out_dist_q  <= out_dist_d;
    if (in_accept) begin
      pix_r_q <= red_i;
      pix_g_q <= green_i;
      pix_b_q <= blue_i;
      last_q  <= last_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign nearest_index_o    = out_idx_q;
  assign nearest_distance_o = out_dist_q;

endmodule

// ----- src/npcs_checker.sv -----
// Port-level checker for the nearest palette color search, bound to the top level.
// Depends on npcs_pkg and the ports of nearest_palette_color_search.
module npcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          command_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [npcs_pkg::INDEX_W-1:0]  nearest_index_o,
  input logic [npcs_pkg::DIST_W-1:0]   nearest_distance_o
);

  // A result beat stays offered, unchanged, until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nearest_index_o)
                                   && $stable(nearest_distance_o))
    else $error("result beat dropped or changed while stalled");

  // A query beat starts a scan, which holds off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == npcs_pkg::CMD_QUERY) |=> in_stall_o)
    else $error("input not held off after a query beat");

  // A palette write does not hold off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == npcs_pkg::CMD_WRITE) |=> !in_stall_o)
    else $error("input held off after a write beat");

  // A new result only appears at the end of a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nearest_distance_o <= npcs_pkg::DIST_MAX)
    else $error("distance out of range");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (.*);

// ----- verif/npcs_match_board.sv -----
// Scoreboard class for the nearest palette color search testbench.
// Keeps its own palette copy, predicts the nearest entry for every query beat and checks results.
// Depends on npcs_pkg.
package npcs_tb_pkg;
  import npcs_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } match_t;

  class nearest_color_board;
    logic [ENTRY_W-1:0] colors [PALETTE_DEPTH];
    logic [SIZE_W-1:0]  size;
    match_t             expected_matches [$];
    int                 mismatches;

    function new();
      foreach (colors[i]) colors[i] = '0;
      size = SIZE_RESET;
      mismatches = 0;
    endfunction

    function void set_size(logic [SIZE_W-1:0] value);
      size = value;
    endfunction

    // A size of zero still scans entry 0, and anything past the depth scans the whole palette.
    function int scan_length();
      if (size == 0) return 1;
      if (size > PALETTE_DEPTH) return PALETTE_DEPTH;
      return int'(size);
    endfunction

    static function logic [DIST_W-1:0] channel_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      return (a > b) ? DIST_W'(a - b) : DIST_W'(b - a);
    endfunction

    function logic [DIST_W-1:0] distance_to(int entry, logic [CHAN_W-1:0] r,
                                            logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
      logic [ENTRY_W-1:0] c;
      c = colors[entry];
      return channel_gap(r, c[2*CHAN_W +: CHAN_W]) + channel_gap(g, c[CHAN_W +: CHAN_W])
           + channel_gap(b, c[0 +: CHAN_W]);
    endfunction

    // Only a strictly smaller distance replaces the best, so ties keep the lowest index.
    function match_t nearest_entry(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                   logic [CHAN_W-1:0] b);
      match_t             best;
      logic [DIST_W-1:0]  d;
      int                 n;
      n = scan_length();
      best.index    = '0;
      best.distance = distance_to(0, r, g, b);
      for (int i = 1; i < n; i++) begin
        d = distance_to(i, r, g, b);
        if (d < best.distance) begin
          best.distance = d;
          best.index    = INDEX_W'(i);
        end
      end
      return best;
    endfunction

    function void note_beat(cmd_e cmd, logic [INDEX_W-1:0] entry, logic [CHAN_W-1:0] r,
                            logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
      if (cmd == CMD_WRITE) begin
        if (int'(entry) < PALETTE_DEPTH) colors[entry] = {r, g, b};
      end else begin
        expected_matches = {expected_matches, nearest_entry(r, g, b)};
      end
    endfunction

    function void flag(string field, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_match(logic [INDEX_W-1:0] index, logic [DIST_W-1:0] distance);
      match_t want;
      if (expected_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH result with nothing expected: index %0d, distance %0d",
                   index, distance);
        return;
      end
      want = expected_matches.pop_front();
      if (index !== want.index) flag("nearest_index", DIST_W'(want.index), DIST_W'(index));
      if (distance !== want.distance) flag("nearest_distance", want.distance, distance);
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction
  endclass

endpackage

// ----- verif/tb_nearest_palette_color_search.sv -----
// Testbench top for nearest_palette_color_search: drives write and query beats with random
// gaps and output stalls, changes palette_size between phases and checks every result.
// Depends on npcs_pkg, npcs_tb_pkg and the block's RTL.
module tb_nearest_palette_color_search;
  import npcs_pkg::*;
  import npcs_tb_pkg::*;

  localparam int MAX_GAP       = 13;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 80;
  localparam int PHASES        = 11;
  localparam int PHASE_BEATS   = 67;

  typedef struct {
    cmd_e               cmd;
    logic [INDEX_W-1:0] entry;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } beat_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [INDEX_W-1:0] entry_index_i;
  logic [CHAN_W-1:0]  red_i;
  logic [CHAN_W-1:0]  green_i;
  logic [CHAN_W-1:0]  blue_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [INDEX_W-1:0] nearest_index_o;
  logic [DIST_W-1:0]  nearest_distance_o;
  logic               cfg_we_i;
  logic [SIZE_W-1:0]  cfg_wdata_i;

  nearest_color_board board = new();
  bit                 written [PALETTE_DEPTH];
  bit                 calm_source;
  bit                 calm_sink;
  bit                 hold_request;
  int                 quiet_cycles;

  nearest_palette_color_search dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .entry_index_i      (entry_index_i),
    .red_i              (red_i),
    .green_i            (green_i),
    .blue_i             (blue_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .nearest_index_o    (nearest_index_o),
    .nearest_distance_o (nearest_distance_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic beat_t make_beat(cmd_e cmd, int entry, int r, int g, int b);
    beat_t beat;
    beat.cmd   = cmd;
    beat.entry = INDEX_W'(entry);
    beat.red   = CHAN_W'(r);
    beat.green = CHAN_W'(g);
    beat.blue  = CHAN_W'(b);
    return beat;
  endfunction

  // Extremes and a mid value show up often so that ties and maximal distances are common.
  function automatic logic [CHAN_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return CHAN_W'(8'h80);
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_beat(beat_t beat);
    int gap;
    gap = calm_source ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    command_i     <= beat.cmd;
    entry_index_i <= beat.entry;
    red_i         <= beat.red;
    green_i       <= beat.green;
    blue_i        <= beat.blue;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(beat.cmd, beat.entry, beat.red, beat.green, beat.blue);
    if (beat.cmd == CMD_WRITE) written[beat.entry] = 1'b1;
  endtask

  // Drops valid, then waits for every expected result plus a short margin for a trailing write.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_size(value);
  endtask

  // Queries go out only once every scanned entry has been written; until then the
  // generator favors writes to the missing entries.
  task automatic run_random_phase(int count);
    int    n;
    int    start;
    int    slot;
    int    pick;
    beat_t beat;
    for (int k = 0; k < count; k++) begin
      n     = board.scan_length();
      slot  = -1;
      start = $urandom_range(0, n - 1);
      for (int j = 0; j < n; j++)
        if (slot < 0 && !written[(start + j) % n]) slot = (start + j) % n;
      if (slot < 0 && $urandom_range(0, 99) < 60) begin
        beat = make_beat(CMD_QUERY, $urandom_range(0, PALETTE_DEPTH - 1),
                         pick_channel(), pick_channel(), pick_channel());
        if ($urandom_range(0, 3) == 0) begin
          pick       = $urandom_range(0, n - 1);
          beat.red   = board.colors[pick][2*CHAN_W +: CHAN_W];
          beat.green = board.colors[pick][CHAN_W +: CHAN_W];
          beat.blue  = board.colors[pick][0 +: CHAN_W];
        end
      end else begin
        pick = (slot >= 0 && $urandom_range(0, 3) != 0) ? slot
                                                        : $urandom_range(0, PALETTE_DEPTH - 1);
        beat = make_beat(CMD_WRITE, pick, pick_channel(), pick_channel(), pick_channel());
        // Copying another entry's color gives duplicate entries and thus tied distances.
        if ($urandom_range(0, 4) == 0)
          {beat.red, beat.green, beat.blue} =
              board.colors[$urandom_range(0, PALETTE_DEPTH - 1)];
      end
      send_beat(beat);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_match(nearest_index_o, nearest_distance_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: a random stall before each beat, or one long hold when requested.
  initial begin
    int wait_cycles;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles  = HOLD_CYCLES;
      end else begin
        wait_cycles = calm_sink ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (wait_cycles > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (wait_cycles - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    logic [SIZE_W-1:0] phase_sizes [PHASES];
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_WRITE;
    entry_index_i = '0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    calm_source   = 1'b0;
    calm_sink     = 1'b0;
    hold_request  = 1'b0;
    quiet_cycles  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: black and white entries, a duplicate of entry 0 for a tie, and an entry
    // at the top index that a small palette must not see.
    write_size(SIZE_W'(4));
    send_beat(make_beat(CMD_WRITE, 0, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(CMD_WRITE, 1, 8'hFF, 8'hFF, 8'hFF));
    send_beat(make_beat(CMD_WRITE, 2, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(CMD_WRITE, 3, 8'h80, 8'h40, 8'h20));
    send_beat(make_beat(CMD_WRITE, 63, 8'hFF, 8'h00, 8'hFF));
    send_beat(make_beat(CMD_QUERY, 63, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(CMD_QUERY, 0, 8'hFF, 8'hFF, 8'hFF));
    send_beat(make_beat(CMD_QUERY, 21, 8'hFF, 8'h00, 8'hFF));
    send_beat(make_beat(CMD_QUERY, 42, 8'h80, 8'h80, 8'h80));
    send_beat(make_beat(CMD_QUERY, 7, 8'h7F, 8'h3F, 8'h1F));
    // A zero size still searches entry 0, which gives the largest possible distance here.
    write_size(SIZE_W'(0));
    send_beat(make_beat(CMD_QUERY, 0, 8'hFF, 8'hFF, 8'hFF));
    send_beat(make_beat(CMD_QUERY, 0, 8'h01, 8'h02, 8'h03));
    write_size(SIZE_W'(1));
    send_beat(make_beat(CMD_QUERY, 63, 8'hFF, 8'h00, 8'h00));

    phase_sizes = '{SIZE_W'(16), SIZE_W'(2), SIZE_W'(64), SIZE_W'(0), SIZE_W'(127),
                    SIZE_W'(1), SIZE_W'(0), SIZE_W'(64), SIZE_W'(0), SIZE_W'(0), SIZE_W'(5)};
    phase_sizes[6] = SIZE_W'($urandom_range(3, 63));
    phase_sizes[8] = SIZE_W'($urandom_range(65, 126));
    phase_sizes[9] = SIZE_W'($urandom_range(3, 63));

    for (int p = 0; p < PHASES; p++) begin
      write_size(phase_sizes[p]);
      calm_source = (p % 4 == 1);
      calm_sink   = (p % 4 == 2);
      // Phases 1 and 6 hold the output long; phase 1 also has a small palette and gap-free beats.
      if (p == 1 || p == 6) hold_request = 1'b1;
      run_random_phase(PHASE_BEATS);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
